FILE: hw/rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int PIXEL_W = 24;
    localparam int CH_W    = 8;
    localparam int HUE_W   = 16;
    localparam int SAT_W   = 13;
    localparam int VAL_W   = 8;

    // hue numerator spans [0, 6 * 255)
    localparam int NUM_W   = 11;

    localparam int HUE_BITS_DEF      = 16;
    localparam int SAT_FRAC_BITS_DEF = 12;

endpackage

FILE: hw/rtl/rgbhsv_pixel_if.sv
interface rgbhsv_pixel_if;

    logic                              valid;
    logic                              ready;
    logic [rgbhsv_pkg::PIXEL_W-1:0]    pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

FILE: hw/rtl/rgbhsv_result_if.sv
interface rgbhsv_result_if;

    logic                              valid;
    logic                              ready;
    logic [rgbhsv_pkg::HUE_W-1:0]      hue;
    logic [rgbhsv_pkg::SAT_W-1:0]      saturation;
    logic [rgbhsv_pkg::VAL_W-1:0]      brightness;
    logic                              achromatic;

    modport source (output valid, output hue, output saturation, output brightness,
                    output achromatic, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input achromatic, output ready);

endinterface

FILE: hw/rtl/rgb_to_hsv_convert_top.sv
// RGB to HSV pixel converter.
// i_pix (sink): one packed RGB pixel per transaction, red 23..16, green 15..8,
//   blue 7..0.
// o_hsv (source): one result per pixel, in order: hue as a fraction of a full
//   turn, saturation in unsigned Q1.SAT_FRAC_BITS, brightness (largest byte)
//   and an achromatic flag (grey pixel, hue then 0).
// Five register stages: min/max and hue numerator, reciprocal table lookup,
// reciprocal multiply, quotient back-multiply, remainder correction into the
// output register. Throughput is one pixel per cycle while o_hsv is not
// stalling; every stage is a single register step.
// When o_hsv.ready is low with a valid result, the whole pipeline holds and
// i_pix.ready drops; nothing is lost or repeated. Empty stages are not
// compacted during a stall.
// Reset (synchronous, active low) clears all stage valid bits; no clearing
// pass is needed and a pixel can be taken in the first cycle after reset.
module rgb_to_hsv_convert_top #(
    parameter int HUE_BITS      = rgbhsv_pkg::HUE_BITS_DEF,
    parameter int SAT_FRAC_BITS = rgbhsv_pkg::SAT_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    rgbhsv_pixel_if.sink            i_pix,
    rgbhsv_result_if.source         o_hsv
);

    localparam int CH_W  = rgbhsv_pkg::CH_W;
    localparam int NUM_W = rgbhsv_pkg::NUM_W;
    localparam int TAB_N = 1 << CH_W;
    localparam int KS    = SAT_FRAC_BITS + CH_W;
    localparam int RS_W  = KS + 1;
    localparam int KH    = HUE_BITS + NUM_W;
    localparam int RH_W  = KH - 2;
    localparam int PS_W  = CH_W + RS_W;
    localparam int PH_W  = NUM_W + RH_W;
    localparam int SQ_W  = SAT_FRAC_BITS + 1;
    localparam int PMS_W = SQ_W + CH_W;
    localparam int PMH_W = HUE_BITS + NUM_W;
    localparam int SA_W  = SAT_FRAC_BITS + CH_W + 2;
    localparam int HA_W  = HUE_BITS + NUM_W + 1;

    logic [RS_W-1:0] w_sat_rcp [TAB_N];
    logic [RH_W-1:0] w_hue_rcp [TAB_N];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_rcp
        localparam logic [63:0] SR = (gi == 0) ? 64'd0 : (64'd1 << KS) / 64'(gi);
        localparam logic [63:0] HR = (gi == 0) ? 64'd0 : (64'd1 << KH) / (64'd6 * 64'(gi));
        assign w_sat_rcp[gi] = SR[RS_W-1:0];
        assign w_hue_rcp[gi] = HR[RH_W-1:0];
    end

    logic       w_adv;
    logic [4:0] r_vld;

    assign w_adv       = !r_vld[4] || o_hsv.ready;
    assign i_pix.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_pix.valid};
        end
    end

    // stage A: extremes and hue numerator
    logic [CH_W-1:0]  w_r, w_g, w_b;
    logic [CH_W-1:0]  n_a_mx, n_a_mn, n_a_delta;
    logic [NUM_W-1:0] n_a_num, w_a_d11, w_a_d6;

    assign w_r = i_pix.pixel[23:16];
    assign w_g = i_pix.pixel[15:8];
    assign w_b = i_pix.pixel[7:0];

    always_comb begin
        n_a_mx = w_r;
        if (w_g > n_a_mx) begin
            n_a_mx = w_g;
        end
        if (w_b > n_a_mx) begin
            n_a_mx = w_b;
        end
        n_a_mn = w_r;
        if (w_g < n_a_mn) begin
            n_a_mn = w_g;
        end
        if (w_b < n_a_mn) begin
            n_a_mn = w_b;
        end
        n_a_delta = n_a_mx - n_a_mn;
        w_a_d11   = NUM_W'(n_a_delta);
        w_a_d6    = (w_a_d11 << 2) + (w_a_d11 << 1);
        if (w_r == n_a_mx) begin
            if (w_g >= w_b) begin
                n_a_num = NUM_W'(w_g) - NUM_W'(w_b);
            end else begin
                n_a_num = w_a_d6 - (NUM_W'(w_b) - NUM_W'(w_g));
            end
        end else if (w_g == n_a_mx) begin
            n_a_num = (w_a_d11 << 1) + NUM_W'(w_b) - NUM_W'(w_r);
        end else begin
            n_a_num = (w_a_d11 << 2) + NUM_W'(w_r) - NUM_W'(w_g);
        end
    end

    logic [CH_W-1:0]  r_a_mx, r_a_delta;
    logic [NUM_W-1:0] r_a_num;
    logic             r_a_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_mx    <= n_a_mx;
            r_a_delta <= n_a_delta;
            r_a_num   <= n_a_num;
            r_a_grey  <= (n_a_delta == '0);
        end
    end

    // stage B: reciprocal lookup
    logic [CH_W-1:0]  r_b_mx, r_b_delta;
    logic [NUM_W-1:0] r_b_num, r_b_d6, n_b_d6, w_b_d11;
    logic [RS_W-1:0]  r_b_rs;
    logic [RH_W-1:0]  r_b_rh;
    logic             r_b_grey;

    assign w_b_d11 = NUM_W'(r_a_delta);
    assign n_b_d6  = (w_b_d11 << 2) + (w_b_d11 << 1);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_mx    <= r_a_mx;
            r_b_delta <= r_a_delta;
            r_b_num   <= r_a_num;
            r_b_d6    <= n_b_d6;
            r_b_grey  <= r_a_grey;
            r_b_rs    <= w_sat_rcp[r_a_mx];
            r_b_rh    <= w_hue_rcp[r_a_delta];
        end
    end

    // stage C: reciprocal multiply
    logic [CH_W-1:0]  r_c_mx, r_c_delta;
    logic [NUM_W-1:0] r_c_num, r_c_d6;
    logic [PS_W-1:0]  r_c_ps;
    logic [PH_W-1:0]  r_c_ph;
    logic             r_c_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_mx    <= r_b_mx;
            r_c_delta <= r_b_delta;
            r_c_num   <= r_b_num;
            r_c_d6    <= r_b_d6;
            r_c_grey  <= r_b_grey;
            r_c_ps    <= PS_W'(r_b_delta) * PS_W'(r_b_rs);
            r_c_ph    <= PH_W'(r_b_num) * PH_W'(r_b_rh);
        end
    end

    // stage D: quotient estimate and back-multiply
    logic [SQ_W-1:0]     n_d_qs, r_d_qs;
    logic [HUE_BITS-1:0] n_d_qh, r_d_qh;
    logic [PMS_W-1:0]    r_d_pms;
    logic [PMH_W-1:0]    r_d_pmh;
    logic [CH_W-1:0]     r_d_mx, r_d_delta;
    logic [NUM_W-1:0]    r_d_num, r_d_d6;
    logic                r_d_grey;

    assign n_d_qs = r_c_ps[CH_W +: SQ_W];
    assign n_d_qh = r_c_ph[NUM_W +: HUE_BITS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_qs    <= n_d_qs;
            r_d_qh    <= n_d_qh;
            r_d_pms   <= PMS_W'(n_d_qs) * PMS_W'(r_c_mx);
            r_d_pmh   <= PMH_W'(n_d_qh) * PMH_W'(r_c_d6);
            r_d_mx    <= r_c_mx;
            r_d_delta <= r_c_delta;
            r_d_num   <= r_c_num;
            r_d_d6    <= r_c_d6;
            r_d_grey  <= r_c_grey;
        end
    end

    // stage E: remainder correction
    logic [SA_W-1:0]     w_e_as;
    logic [HA_W-1:0]     w_e_ah;
    logic                w_e_sfix, w_e_hfix;
    logic [SQ_W-1:0]     n_e_sat;
    logic [HUE_BITS-1:0] n_e_hue;
    logic [SQ_W+rgbhsv_pkg::SAT_W-1:0]     w_e_sat_ext;
    logic [HUE_BITS+rgbhsv_pkg::HUE_W-1:0] w_e_hue_ext;

    assign w_e_as   = SA_W'(r_d_delta) << SAT_FRAC_BITS;
    assign w_e_ah   = HA_W'(r_d_num) << HUE_BITS;
    assign w_e_sfix = w_e_as >= (SA_W'(r_d_pms) + SA_W'(r_d_mx));
    assign w_e_hfix = w_e_ah >= (HA_W'(r_d_pmh) + HA_W'(r_d_d6));
    assign n_e_sat  = (r_d_mx == '0) ? '0 : r_d_qs + SQ_W'(w_e_sfix);
    assign n_e_hue  = r_d_grey ? '0 : r_d_qh + HUE_BITS'(w_e_hfix);

    assign w_e_sat_ext = (SQ_W + rgbhsv_pkg::SAT_W)'(n_e_sat);
    assign w_e_hue_ext = (HUE_BITS + rgbhsv_pkg::HUE_W)'(n_e_hue);

    logic [rgbhsv_pkg::HUE_W-1:0] r_o_hue;
    logic [rgbhsv_pkg::SAT_W-1:0] r_o_sat;
    logic [rgbhsv_pkg::VAL_W-1:0] r_o_val;
    logic                         r_o_achr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_hue  <= w_e_hue_ext[rgbhsv_pkg::HUE_W-1:0];
            r_o_sat  <= w_e_sat_ext[rgbhsv_pkg::SAT_W-1:0];
            r_o_val  <= r_d_mx;
            r_o_achr <= r_d_grey;
        end
    end

    assign o_hsv.valid      = r_vld[4];
    assign o_hsv.hue        = r_o_hue;
    assign o_hsv.saturation = r_o_sat;
    assign o_hsv.brightness = r_o_val;
    assign o_hsv.achromatic = r_o_achr;

endmodule

FILE: hw/rtl/rgbhsv_chk.sv
module rgbhsv_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [rgbhsv_pkg::HUE_W-1:0]       i_hue,
    input logic [rgbhsv_pkg::SAT_W-1:0]       i_sat,
    input logic [rgbhsv_pkg::VAL_W-1:0]       i_val,
    input logic                               i_achr
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hue) && $stable(i_sat) && $stable(i_val)
            && $stable(i_achr))
        else $error("result changed while stalled");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled while output side free");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_achr |-> i_hue == '0 && i_sat == '0)
        else $error("grey pixel with nonzero hue or saturation");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_val == '0 |-> i_achr)
        else $error("black pixel not flagged achromatic");

endmodule

bind rgb_to_hsv_convert_top rgbhsv_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsv.valid),
    .i_out_ready (o_hsv.ready),
    .i_hue       (o_hsv.hue),
    .i_sat       (o_hsv.saturation),
    .i_val       (o_hsv.brightness),
    .i_achr      (o_hsv.achromatic)
);
